// ===== sv/mosaic_bitmap_blitter_assert.svh =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter assertion macros
// Shared wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MOSAIC_BITMAP_BLITTER_ASSERT_SVH
`define MOSAIC_BITMAP_BLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MBB_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MBB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter package
// Grid geometry, opcodes, register indexes and the structs between modules.
// ----------------------------------------------------------------------------
package mbb_pkg;

  // Grid geometry
  localparam int GRID_COLS   = 80;
  localparam int GRID_ROWS   = 75;
  localparam int GRID_PIXELS = GRID_COLS * GRID_ROWS;
  localparam int STORE_BYTES = (GRID_PIXELS + 7) / 8;
  localparam int COL_W       = $clog2(GRID_COLS);
  localparam int ROW_W       = $clog2(GRID_ROWS);
  localparam int IDX_W       = $clog2(GRID_PIXELS);
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COORD_W     = 11;

  // Request opcodes
  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_PLOT      = 3'd1;
  localparam logic [2:0] OP_STAMP     = 3'd2;
  localparam logic [2:0] OP_READ_PX   = 3'd3;
  localparam logic [2:0] OP_READ_CELL = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPR_W     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPR_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 3'd5;

  // Pixel unit operations
  localparam logic [1:0] PX_READ      = 2'd0;
  localparam logic [1:0] PX_SET       = 2'd1;
  localparam logic [1:0] PX_RESET     = 2'd2;
  localparam logic [1:0] PX_CLEAR_ALL = 2'd3;

  typedef struct packed {
    logic [7:0]  char_base;
    logic [3:0]  sprite_width;
    logic [3:0]  sprite_height;
    logic [2:0]  sprite_anchor_x;
    logic [2:0]  sprite_anchor_y;
    logic [63:0] sprite_pattern;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } px_req_t;

  typedef struct packed {
    logic ready;
    logic idle;
    logic done;
    logic value;
  } px_rsp_t;

  typedef struct packed {
    logic       load;
    logic       pixel_value;
    logic [7:0] cell_code;
  } seq_result_t;

endpackage

// ===== sv/mbb_if.sv =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter channels
// Command and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mbb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic              pixel_on;
  logic [5:0]        cell_col;
  logic [4:0]        cell_row;

  modport source (output valid, opcode, pos_x, pos_y, pixel_on, cell_col, cell_row,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pixel_on, cell_col, cell_row,
                output ready);
endinterface

interface mbb_rsp_if;
  logic       valid;
  logic       ready;
  logic       pixel_value;
  logic [7:0] cell_code;

  modport source (output valid, pixel_value, cell_code, input ready);
  modport sink (input valid, pixel_value, cell_code, output ready);
endinterface

// ===== sv/mbb_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter pixel unit
// Byte-wide bitmap store with clipped single-pixel read, set and reset, and a full clear.
// ----------------------------------------------------------------------------
module mbb_pixel_unit (
  input  logic             clk,
  input  logic             rst,
  input  mbb_pkg::px_req_t req,
  output mbb_pkg::px_rsp_t rsp
);

  localparam logic [1:0] PU_IDLE  = 2'd0;
  localparam logic [1:0] PU_ADDR  = 2'd1;
  localparam logic [1:0] PU_MOD   = 2'd2;
  localparam logic [1:0] PU_CLEAR = 2'd3;

  logic [1:0]                 state;
  logic [mbb_pkg::ADDR_W-1:0] clr_addr;
  logic [1:0]                 op_r;
  logic                       inside_r;
  logic [mbb_pkg::COL_W-1:0]  xg;
  logic [mbb_pkg::ROW_W-1:0]  yg;
  logic [mbb_pkg::ADDR_W-1:0] byte_addr;
  logic [2:0]                 bit_sel;
  logic [7:0]                 rdata;
  logic [7:0]                 mem [mbb_pkg::STORE_BYTES];

  logic                       take;
  logic                       in_grid;
  logic [mbb_pkg::IDX_W-1:0]  idx;
  logic [mbb_pkg::ADDR_W-1:0] rd_addr;
  logic                       rd_en;
  logic                       wr_en;
  logic [mbb_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                 wr_data;
  logic [7:0]                 mask;

  assign rsp.ready = (state == PU_IDLE) || (state == PU_MOD);
  assign rsp.idle  = (state == PU_IDLE);
  assign rsp.done  = (state == PU_MOD);
  assign rsp.value = inside_r && rdata[3'd7 - bit_sel];

  assign take    = req.valid && rsp.ready;
  assign in_grid = !req.x[mbb_pkg::COORD_W-1] && !req.y[mbb_pkg::COORD_W-1] &&
                   (req.x[mbb_pkg::COORD_W-2:0] < (mbb_pkg::COORD_W-1)'(mbb_pkg::GRID_COLS)) &&
                   (req.y[mbb_pkg::COORD_W-2:0] < (mbb_pkg::COORD_W-1)'(mbb_pkg::GRID_ROWS));

  assign idx     = mbb_pkg::IDX_W'(yg) * mbb_pkg::IDX_W'(mbb_pkg::GRID_COLS)
                 + mbb_pkg::IDX_W'(xg);
  assign rd_addr = mbb_pkg::ADDR_W'(idx >> 3);
  assign rd_en   = (state == PU_ADDR) && inside_r;

  assign mask    = 8'h80 >> bit_sel;
  assign wr_en   = (state == PU_CLEAR) ||
                   ((state == PU_MOD) && inside_r && (op_r != mbb_pkg::PX_READ));
  assign wr_addr = (state == PU_CLEAR) ? clr_addr : byte_addr;
  assign wr_data = (state == PU_CLEAR)           ? 8'h00 :
                   (op_r == mbb_pkg::PX_SET)     ? (rdata | mask) : (rdata & ~mask);

  // Sequencer; a new request may enter while the previous write lands
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= PU_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state) inside
        PU_IDLE, PU_MOD: begin
          if (req.valid) begin
            if (req.op == mbb_pkg::PX_CLEAR_ALL) begin
              state    <= PU_CLEAR;
              clr_addr <= '0;
            end else begin
              state <= PU_ADDR;
            end
          end else begin
            state <= PU_IDLE;
          end
        end
        PU_ADDR: begin
          state <= PU_MOD;
        end
        PU_CLEAR: begin
          if (clr_addr == mbb_pkg::ADDR_W'(mbb_pkg::STORE_BYTES - 1)) begin
            state <= PU_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        default: begin
          state <= PU_IDLE;
        end
      endcase
    end
  end

  // Latch the clipped coordinates, then the byte address and bit
  always_ff @(posedge clk) begin
    if (take) begin
      op_r     <= req.op;
      inside_r <= in_grid;
      xg       <= req.x[mbb_pkg::COL_W-1:0];
      yg       <= req.y[mbb_pkg::ROW_W-1:0];
    end
    if (state == PU_ADDR) begin
      byte_addr <= rd_addr;
      bit_sel   <= idx[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/mbb_sequencer.sv =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter sequencer
// Decodes a request and walks it as pixel requests to the pixel unit.
// ----------------------------------------------------------------------------
module mbb_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  mbb_cmd_if.sink              cmd,
  input  mbb_pkg::cfg_t        cfg,
  output mbb_pkg::px_req_t     preq,
  input  mbb_pkg::px_rsp_t     prsp,
  input  logic                 out_free,
  output mbb_pkg::seq_result_t res
);

  localparam logic [1:0] SQ_IDLE   = 2'd0;
  localparam logic [1:0] SQ_ISSUE  = 2'd1;
  localparam logic [1:0] SQ_DRAIN  = 2'd2;
  localparam logic [1:0] SQ_RESULT = 2'd3;

  logic [1:0]        state;
  logic [2:0]        op_r;
  logic signed [8:0] px_r;
  logic signed [8:0] py_r;
  logic              on_r;
  logic [6:0]        sx_r;
  logic [6:0]        sy_r;
  logic [3:0]        col_cnt;
  logic [3:0]        row_cnt;
  logic [7:0]        k_cnt;
  logic [2:0]        iss_cnt;
  logic [2:0]        done_cnt;
  logic [5:0]        bits_r;
  logic              pix_r;

  logic                              accept;
  logic                              spr_on;
  logic                              step;
  logic                              last_pos;
  logic signed [mbb_pkg::COORD_W-1:0] px_ext;
  logic signed [mbb_pkg::COORD_W-1:0] py_ext;

  assign cmd.ready = (state == SQ_IDLE) && prsp.idle;
  assign accept    = cmd.valid && cmd.ready;

  assign px_ext   = {{2{px_r[8]}}, px_r};
  assign py_ext   = {{2{py_r[8]}}, py_r};
  assign spr_on   = (k_cnt < 8'd64) && cfg.sprite_pattern[~k_cnt[5:0]];
  assign last_pos = (col_cnt == cfg.sprite_width - 4'd1) &&
                    (row_cnt == cfg.sprite_height - 4'd1);

  // Build the pixel request for the current step
  always_comb begin
    preq.valid = 1'b0;
    preq.op    = mbb_pkg::PX_READ;
    preq.x     = px_ext;
    preq.y     = py_ext;
    if (state == SQ_ISSUE) begin
      case (op_r)
        mbb_pkg::OP_CLEAR: begin
          preq.valid = 1'b1;
          preq.op    = mbb_pkg::PX_CLEAR_ALL;
        end
        mbb_pkg::OP_PLOT: begin
          preq.valid = 1'b1;
          preq.op    = on_r ? mbb_pkg::PX_SET : mbb_pkg::PX_RESET;
        end
        mbb_pkg::OP_READ_PX: begin
          preq.valid = 1'b1;
        end
        mbb_pkg::OP_READ_CELL: begin
          preq.valid = 1'b1;
          preq.x     = {4'b0, sx_r} + {10'b0, iss_cnt[0]};
          preq.y     = {4'b0, sy_r} + {9'b0, iss_cnt[2:1]};
        end
        mbb_pkg::OP_STAMP: begin
          preq.valid = spr_on;
          preq.op    = mbb_pkg::PX_SET;
          preq.x     = px_ext + {7'b0, col_cnt} - {8'b0, cfg.sprite_anchor_x};
          preq.y     = py_ext + {7'b0, row_cnt} - {8'b0, cfg.sprite_anchor_y};
        end
        default: begin
          preq.valid = 1'b0;
        end
      endcase
    end
  end

  // Stamp moves on when the pixel is off or its request is taken
  assign step = !spr_on || prsp.ready;

  assign res.load        = (state == SQ_RESULT) && out_free;
  assign res.pixel_value = (op_r == mbb_pkg::OP_READ_PX) ? pix_r : 1'b0;
  assign res.cell_code   = (op_r == mbb_pkg::OP_READ_CELL) ?
                           (cfg.char_base | {2'b0, bits_r}) : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      unique case (state)
        SQ_IDLE: begin
          if (accept) begin
            case (cmd.opcode) inside
              mbb_pkg::OP_CLEAR, mbb_pkg::OP_PLOT, mbb_pkg::OP_READ_PX,
              mbb_pkg::OP_READ_CELL: begin
                state <= SQ_ISSUE;
              end
              mbb_pkg::OP_STAMP: begin
                if ((cfg.sprite_width != 4'd0) && (cfg.sprite_height != 4'd0)) begin
                  state <= SQ_ISSUE;
                end
              end
              default: begin
                state <= SQ_IDLE;
              end
            endcase
          end
        end
        SQ_ISSUE: begin
          if (op_r == mbb_pkg::OP_STAMP) begin
            if (step && last_pos) begin
              state <= SQ_DRAIN;
            end
          end else if (op_r == mbb_pkg::OP_READ_CELL) begin
            if (prsp.ready && (iss_cnt == 3'd5)) begin
              state <= SQ_DRAIN;
            end
          end else if (prsp.ready) begin
            state <= SQ_DRAIN;
          end
        end
        SQ_DRAIN: begin
          if (prsp.idle) begin
            if ((op_r == mbb_pkg::OP_READ_PX) || (op_r == mbb_pkg::OP_READ_CELL)) begin
              state <= SQ_RESULT;
            end else begin
              state <= SQ_IDLE;
            end
          end
        end
        SQ_RESULT: begin
          if (out_free) begin
            state <= SQ_IDLE;
          end
        end
        default: begin
          state <= SQ_IDLE;
        end
      endcase
    end
  end

  // Request fields, walk counters and collected read bits
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= cmd.opcode;
      px_r     <= cmd.pos_x;
      py_r     <= cmd.pos_y;
      on_r     <= cmd.pixel_on;
      sx_r     <= {cmd.cell_col, 1'b0};
      sy_r     <= {2'b0, cmd.cell_row} + {1'b0, cmd.cell_row, 1'b0};
      col_cnt  <= '0;
      row_cnt  <= '0;
      k_cnt    <= '0;
      iss_cnt  <= '0;
      done_cnt <= '0;
    end else begin
      if ((state == SQ_ISSUE) && (op_r == mbb_pkg::OP_STAMP) && step) begin
        k_cnt <= k_cnt + 8'd1;
        if (col_cnt == cfg.sprite_width - 4'd1) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 4'd1;
        end else begin
          col_cnt <= col_cnt + 4'd1;
        end
      end
      if ((state == SQ_ISSUE) && prsp.ready) begin
        iss_cnt <= iss_cnt + 3'd1;
      end
      if (prsp.done) begin
        done_cnt <= done_cnt + 3'd1;
      end
    end
    if (prsp.done) begin
      pix_r <= prsp.value;
      if (op_r == mbb_pkg::OP_READ_CELL) begin
        bits_r[done_cnt] <= prsp.value;
      end
    end
  end

endmodule

// ===== sv/mosaic_bitmap_blitter.sv =====
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter
// One-bit-per-pixel mosaic bitmap with plot, sprite stamp and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - request channel (valid/ready). Each request carries an opcode:
//          clear, plot pixel, stamp sprite, read pixel or read 2x3 cell.
//   rsp  - result channel (valid/ready). Only the two read opcodes give a
//          result; the other field of that result is zero.
//   cfg  - write-only register port (cfg_wr_en, cfg_index, cfg_data); write
//          only while no request is in progress.
// Timing: one request is worked at a time through a single pixel unit that
//   does one read-modify-write of the byte store per pixel, reading the byte
//   in its address state and writing it back in its modify state. A stamp
//   steps past off sprite positions without a store access; a clear sweeps
//   the store one byte a cycle.
// Reset: registers return to their defaults and the store is swept to zero,
//   one byte a cycle (750 bytes at the default grid); cmd.ready stays low
//   until the sweep ends. Register writes are taken during the sweep.
// Stall: a result sits in the output register until rsp.ready; a following
//   request is still accepted and worked, and holds only at its own result.
// ----------------------------------------------------------------------------
module mosaic_bitmap_blitter (
  input  logic                            clk,
  input  logic                            rst,
  mbb_cmd_if.sink                         cmd,
  mbb_rsp_if.source                       rsp,
  input  logic                            cfg_wr_en,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);

  `include "mosaic_bitmap_blitter_assert.svh"

  mbb_pkg::cfg_t        cfg;
  mbb_pkg::px_req_t     preq;
  mbb_pkg::px_rsp_t     prsp;
  mbb_pkg::seq_result_t res;
  logic                 out_valid;
  logic                 out_pixel;
  logic [7:0]           out_code;
  logic                 out_free;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_base       <= 8'h80;
      cfg.sprite_width    <= 4'd6;
      cfg.sprite_height   <= 4'd4;
      cfg.sprite_anchor_x <= 3'd3;
      cfg.sprite_anchor_y <= 3'd2;
      cfg.sprite_pattern  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mbb_pkg::CFG_CHAR_BASE: cfg.char_base       <= cfg_data[7:0];
        mbb_pkg::CFG_SPR_W:     cfg.sprite_width    <= cfg_data[3:0];
        mbb_pkg::CFG_SPR_H:     cfg.sprite_height   <= cfg_data[3:0];
        mbb_pkg::CFG_ANCHOR_X:  cfg.sprite_anchor_x <= cfg_data[2:0];
        mbb_pkg::CFG_ANCHOR_Y:  cfg.sprite_anchor_y <= cfg_data[2:0];
        mbb_pkg::CFG_PATTERN:   cfg.sprite_pattern  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request decode and pixel walk
  mbb_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .preq     (preq),
    .prsp     (prsp),
    .out_free (out_free),
    .res      (res)
  );

  // Shared pixel read-modify-write unit and byte store
  mbb_pixel_unit u_px (
    .clk (clk),
    .rst (rst),
    .req (preq),
    .rsp (prsp)
  );

  // Output register: load when empty or being drained this cycle
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_pixel <= res.pixel_value;
      out_code  <= res.cell_code;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_value = out_pixel;
  assign rsp.cell_code   = out_code;

  `MBB_CHECK_NOW(a_load_into_free, res.load, !rsp.valid || rsp.ready, "result overwrote a pending result")
  `MBB_CHECK_NOW(a_one_field_set, res.load, (res.pixel_value == 1'b0) || (res.cell_code == 8'h00), "both result fields set")
  `MBB_CHECK_NOW(a_sweep_after_reset, $past(rst), !cmd.ready, "request taken during reset sweep")
  `MBB_CHECK_NEXT(a_busy_after_read, cmd.valid && cmd.ready && (cmd.opcode == mbb_pkg::OP_READ_PX), !cmd.ready, "ready while a pixel read is in progress")

endmodule

// ===== tb/mosaic_bitmap_blitter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mosaic bitmap blitter testbench
// Drives clear, plot, stamp, read and spare-opcode requests through the request
// channel and checks every read result, field by field and in order, against a
// bitmap kept alongside the block. A short directed table comes first. Random
// phases follow, each under its own register setting, with bursty requests and
// a stalling result side.
// ----------------------------------------------------------------------------
module mosaic_bitmap_blitter_tb;
  import mbb_pkg::*;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;

  localparam int DIR_ROWS        = 25;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int FLOOD_ITEMS     = 40;
  // Long result-side hold-off; the block fills and stalls requests meanwhile.
  localparam int RX_HOLD_CYCLES  = 600;
  // A clear sweeps 750 bytes and the largest stamp walks 15x15 positions; let
  // either finish before touching the registers.
  localparam int SETTLE_CYCLES   = 1200;
  // Slowest quiet stretch is the settle wait, the reset sweep or the long
  // hold-off; take it many times over.
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int PRINT_CAP       = 100;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic              pixel_on;
    logic [5:0]        cell_col;
    logic [4:0]        cell_row;
  } blit_req_t;

  typedef struct packed {
    logic       pixel_value;
    logic [7:0] cell_code;
  } read_result_t;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_TYPED,
    EXP_NONE
  } exp_kind_t;

  typedef struct packed {
    blit_req_t    req;
    exp_kind_t    kind;
    read_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  mbb_cmd_if cmd_ch ();
  mbb_rsp_if rsp_ch ();

  mosaic_bitmap_blitter uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bitmap mirror: one bit per pixel, row-major, plus the register copy
  // --------------------------------------------------------------------------
  bit           pix_map [GRID_PIXELS];
  cfg_t         blit_cfg;
  read_result_t pending_reads [$];
  read_result_t oldest_read;

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  quiet_cycles   = 0;
  int  burst_left     = 0;
  int  flood_left     = 0;
  bit  rx_hold_req    = 1'b0;

  // Directed table. Typed rows carry results that are plain from the state:
  // empty bitmap, pixels just set at the corners, and clipped coordinates.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{OP_READ_PX,   0,    0,    0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_READ_CELL, 0,    0,    0, 0,  0},  EXP_TYPED,   '{0, 8'h80}},
    '{'{OP_READ_PX,   -256, -256, 0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_READ_PX,   255,  255,  0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_PLOT,      0,    0,    1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_PX,   0,    0,    0, 0,  0},  EXP_TYPED,   '{1, 8'h00}},
    '{'{OP_PLOT,      79,   74,   1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_PX,   79,   74,   0, 0,  0},  EXP_TYPED,   '{1, 8'h00}},
    '{'{OP_READ_CELL, 0,    0,    0, 39, 24}, EXP_TYPED,   '{0, 8'hA0}},
    '{'{OP_PLOT,      -256, 0,    1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_PLOT,      0,    255,  1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_PX,   -1,   0,    0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_READ_PX,   80,   0,    0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_READ_PX,   0,    75,   0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_READ_CELL, 0,    0,    0, 63, 31}, EXP_TYPED,   '{0, 8'h80}},
    '{'{OP_STAMP,     40,   37,   1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_PLOT,      1,    0,    1, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_CELL, 0,    0,    0, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_SPARE0,    -1,   -1,   1, 63, 31}, EXP_NONE,    '{0, 8'h00}},
    '{'{OP_SPARE1,    0,    0,    0, 0,  0},  EXP_NONE,    '{0, 8'h00}},
    '{'{OP_SPARE2,    255,  -256, 1, 42, 21}, EXP_NONE,    '{0, 8'h00}},
    '{'{OP_PLOT,      0,    0,    0, 0,  0},  EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_PX,   0,    0,    0, 0,  0},  EXP_TYPED,   '{0, 8'h00}},
    '{'{OP_CLEAR,     -1,   -1,   1, 63, 31}, EXP_PREDICT, '{0, 8'h00}},
    '{'{OP_READ_PX,   79,   74,   0, 0,  0},  EXP_TYPED,   '{0, 8'h00}}
  };

  function automatic bit pixel_at(input int x, input int y);
    if (x < 0 || y < 0 || x >= GRID_COLS || y >= GRID_ROWS) return 1'b0;
    return pix_map[y * GRID_COLS + x];
  endfunction

  // Drop anything that falls outside the grid.
  function automatic void put_pixel(input int x, input int y, input bit on);
    if (x < 0 || y < 0 || x >= GRID_COLS || y >= GRID_ROWS) return;
    pix_map[y * GRID_COLS + x] = on;
  endfunction

  // Apply one request to the mirror; return the read result if it makes one.
  function automatic void bitmap_apply(input blit_req_t req, output bit has_read,
                                       output read_result_t res);
    int px;
    int py;
    int sx;
    int sy;
    int k;
    px = $signed(req.pos_x);
    py = $signed(req.pos_y);
    sx = int'(req.cell_col) * 2;
    sy = int'(req.cell_row) * 3;
    has_read = 1'b0;
    res = '0;
    case (req.opcode)
      OP_CLEAR: begin
        foreach (pix_map[i]) pix_map[i] = 1'b0;
      end
      OP_PLOT: begin
        put_pixel(px, py, req.pixel_on);
      end
      OP_STAMP: begin
        // Set only on pixels; sprite bits past the 64th read as off.
        for (int r = 0; r < int'(blit_cfg.sprite_height); r++) begin
          for (int c = 0; c < int'(blit_cfg.sprite_width); c++) begin
            k = r * int'(blit_cfg.sprite_width) + c;
            if (k < 64 && blit_cfg.sprite_pattern[63 - k])
              put_pixel(px + c - int'(blit_cfg.sprite_anchor_x),
                        py + r - int'(blit_cfg.sprite_anchor_y), 1'b1);
          end
        end
      end
      OP_READ_PX: begin
        has_read = 1'b1;
        res.pixel_value = pixel_at(px, py);
      end
      OP_READ_CELL: begin
        // Bits 1,2 top row, 4,8 middle, 16,32 bottom; left pixel first.
        has_read = 1'b1;
        res.cell_code = blit_cfg.char_base;
        for (int i = 0; i < 6; i++)
          if (pixel_at(sx + i % 2, sy + i / 2)) res.cell_code[i] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random request content
  // --------------------------------------------------------------------------
  // Favor a hot corner and the far edges so plots, stamps and reads meet.
  function automatic logic signed [8:0] rand_coord(input int limit);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 35) v = $urandom_range(0, 11);
    else if (pick < 50) v = $urandom_range(limit - 12, limit - 1);
    else if (pick < 75) v = $urandom_range(0, limit - 1);
    else if (pick < 90) v = $urandom_range(0, limit + 7) - 4;
    else v = $urandom_range(0, 511);
    return v[8:0];
  endfunction

  function automatic int rand_cell(input int cells, input int full);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, 5);
    if (pick < 55) return $urandom_range(cells - 6, cells - 1);
    if (pick < 85) return $urandom_range(0, cells - 1);
    return $urandom_range(0, full);
  endfunction

  function automatic blit_req_t random_request();
    blit_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) r.opcode = OP_CLEAR;
    else if (pick < 32) r.opcode = OP_PLOT;
    else if (pick < 47) r.opcode = OP_STAMP;
    else if (pick < 72) r.opcode = OP_READ_PX;
    else if (pick < 97) r.opcode = OP_READ_CELL;
    else begin
      case ($urandom_range(0, 2))
        0:       r.opcode = OP_SPARE0;
        1:       r.opcode = OP_SPARE1;
        default: r.opcode = OP_SPARE2;
      endcase
    end
    r.pos_x    = rand_coord(GRID_COLS);
    r.pos_y    = rand_coord(GRID_ROWS);
    r.pixel_on = ($urandom_range(0, 9) < 7);
    r.cell_col = 6'(rand_cell(GRID_COLS / 2, 63));
    r.cell_row = 5'(rand_cell(GRID_ROWS / 3, 31));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one request, opening a new burst with a random gap when the last
  // one ran out, and record its expectation at the accepting edge.
  task automatic send_request(input blit_req_t req, input exp_kind_t kind,
                              input read_result_t typed);
    int           gap;
    bit           has_read;
    read_result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      if (flood_left > 0) gap = 0;
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= req.opcode;
    cmd_ch.pos_x    <= req.pos_x;
    cmd_ch.pos_y    <= req.pos_y;
    cmd_ch.pixel_on <= req.pixel_on;
    cmd_ch.cell_col <= req.cell_col;
    cmd_ch.cell_row <= req.cell_row;
    do @(posedge clk); while (!cmd_ch.ready);
    bitmap_apply(req, has_read, predicted);
    case (kind)
      EXP_PREDICT: if (has_read) pending_reads.push_back(predicted);
      EXP_TYPED:   pending_reads.push_back(typed);
      default: ;
    endcase
  endtask

  // Drop valid and hold until every pending read has come back.
  task automatic hold_until_answered();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // Reads drained, then give a clear or a stamp time to run out.
  task automatic quiesce();
    hold_until_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back; junk above each field's width must
  // be ignored by the block.
  task automatic write_setting(input cfg_t s);
    logic [63:0]          noise;
    logic [CFG_IDX_W-1:0] idx [6];
    logic [63:0]          field [6];
    noise = {$urandom, $urandom};
    idx = '{CFG_CHAR_BASE, CFG_SPR_W, CFG_SPR_H, CFG_ANCHOR_X, CFG_ANCHOR_Y,
            CFG_PATTERN};
    field[0] = {noise[63:8], s.char_base};
    field[1] = {noise[63:4], s.sprite_width};
    field[2] = {noise[63:4], s.sprite_height};
    field[3] = {noise[63:3], s.sprite_anchor_x};
    field[4] = {noise[63:3], s.sprite_anchor_y};
    field[5] = s.sprite_pattern;
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= field[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    blit_cfg = s;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch on result %0d, %s: got %0h, want %0h",
               $realtime, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Receiver: pick a new random stall mode when the current one runs out; take
  // the long hold-off when asked, counting it here.
  initial begin : receiver
    int mode = 0;
    int left = 0;
    int tick = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 4);
          left = $urandom_range(64, 256);
        end
        left--;
        tick++;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= (tick % 4 == 0);
          3:       rsp_ch.ready <= ($urandom_range(0, 9) != 0);
          default: rsp_ch.ready <= (tick % 32 >= 20);
        endcase
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest pending read.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("result with no read pending", rsp_ch.cell_code, 8'h00);
      end else begin
        oldest_read = pending_reads.pop_front();
        if (rsp_ch.pixel_value !== oldest_read.pixel_value)
          report_mismatch("pixel_value", {7'b0, rsp_ch.pixel_value},
                          {7'b0, oldest_read.pixel_value});
        if (rsp_ch.cell_code !== oldest_read.cell_code)
          report_mismatch("cell_code", rsp_ch.cell_code, oldest_read.cell_code);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run after too long without a handshake on either side.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d reads pending", quiet_cycles,
               pending_reads.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    blit_req_t req;
    cfg_t      phase_cfg [PHASES];

    rst             <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.opcode   <= OP_CLEAR;
    cmd_ch.pos_x    <= '0;
    cmd_ch.pos_y    <= '0;
    cmd_ch.pixel_on <= 1'b0;
    cmd_ch.cell_col <= '0;
    cmd_ch.cell_row <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_CHAR_BASE;
    cfg_data        <= '0;

    // Mirror the reset state: empty bitmap and default registers.
    foreach (pix_map[i]) pix_map[i] = 1'b0;
    blit_cfg = '{8'h80, 4'd6, 4'd4, 3'd3, 3'd2, 64'd0};

    // Settings per phase: defaults with a pattern, a full 8x8 block, a single
    // pixel with the anchor beyond it, zero width, zero height, an oversized
    // 15x15 sprite, a fully random one, and two more ordinary shapes.
    phase_cfg[0] = '{8'h80, 4'd6, 4'd4, 3'd3, 3'd2, {$urandom, $urandom}};
    phase_cfg[1] = '{8'h00, 4'd8, 4'd8, 3'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    phase_cfg[2] = '{8'hFF, 4'd1, 4'd1, 3'd7, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF};
    phase_cfg[3] = '{8'h55, 4'd0, 4'd5, 3'd2, 3'd2, 64'hFFFF_FFFF_FFFF_FFFF};
    phase_cfg[4] = '{8'hA0, 4'd5, 4'd0, 3'd1, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF};
    phase_cfg[5] = '{8'h20, 4'd15, 4'd15, 3'd7, 3'd7, {$urandom, $urandom}};
    phase_cfg[6] = '{8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)), {$urandom, $urandom}};
    phase_cfg[7] = '{8'hC0, 4'd8, 4'd8, 3'd4, 3'd4, {$urandom, $urandom}};
    phase_cfg[8] = '{8'h80, 4'd3, 4'd2, 3'd1, 3'd0, {$urandom, $urandom}};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset registers; the block's clearing sweep
    // holds off the first request until it is done.
    for (int i = 0; i < DIR_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_setting(phase_cfg[p]);
      // Stall the result side for a long stretch while reads pour in.
      if (p == 1) begin
        rx_hold_req = 1'b1;
        flood_left  = FLOOD_ITEMS;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 199) == 0)
          hold_until_answered();
        req = random_request();
        if (flood_left > 0) begin
          req.opcode = ($urandom_range(0, 1) != 0) ? OP_READ_PX : OP_READ_CELL;
          flood_left--;
        end
        send_request(req, EXP_PREDICT, '0);
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
